@@ src/bsng_pkg.sv @@
package bsng_pkg;

  // Window word carried to the back end: up to three history bytes plus the new byte.
  localparam int unsigned WIN_W      = 32;
  localparam int unsigned IDX_IN_W   = 16;
  localparam int unsigned FREQ_W     = 32;
  localparam int unsigned DISTINCT_W = 17;
  localparam int unsigned DIM_W      = 2;

  // Job queue between front and back end.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

  // Operation codes on the input channel.
  typedef enum logic [1:0] {
    FN_DATA  = 2'd0,
    FN_READ  = 2'd1,
    FN_CLEAR = 2'd2
  } func_e;

  // Work handed to the back end.
  typedef enum logic [1:0] {
    JOB_TOKENS = 2'd0,
    JOB_READ   = 2'd1,
    JOB_CLEAR  = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e             kind;
    logic [WIN_W-1:0]      win;
    logic [DIM_W-1:0]      dim;
    logic                  multi;
    logic [IDX_IN_W-1:0]   read_idx;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_SWEEP = 2'd0,
    BK_RUN   = 2'd1,
    BK_DRAIN = 2'd2
  } back_state_e;

endpackage

@@ src/bit_sliding_ngram_histogram.sv @@
// Bit-sliding n-gram histogram over a byte stream.
// Input channel (in_valid_i/in_ready_o) carries one operation per transaction:
// a data byte with its region-start flag, a bin read, or a histogram clear.
// Output channel (out_valid_o/out_ready_i) returns one transaction per read:
// the token value, its saturating count and the number of distinct tokens.
// cfg_we_i writes the n-gram length in bytes; change it only while idle.
// A byte that produces eight tokens makes eight read-modify-writes on the
// counter memory, one per cycle through its read and write ports; a byte
// producing one token makes one, and other bytes make none.
// A read goes through the read and update stages into the output register.
// Incoming transactions are classified and queued (four entries), so the
// input keeps accepting while the back end is busy or the output stalls.
// A stalled result holds in the output register and blocks the next read.
// After reset, and after each clear, the counter memory is swept to zero,
// one entry per cycle, all BIN_COUNT entries; in_ready_o is low meanwhile.
module bit_sliding_ngram_histogram #(
  parameter int unsigned MAX_DIM    = 2,
  parameter int unsigned BIN_COUNT  = 65536,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bsng_pkg::DIM_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          func_i,
  input  logic [7:0]                          data_byte_i,
  input  logic                                region_start_i,
  input  logic [bsng_pkg::IDX_IN_W-1:0]       read_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bsng_pkg::IDX_IN_W-1:0]       token_value_o,
  output logic [bsng_pkg::FREQ_W-1:0]         frequency_o,
  output logic [bsng_pkg::DISTINCT_W-1:0]     distinct_tokens_o
);
  import bsng_pkg::*;

  logic         accept, push, pop, sweeping;
  job_t         push_job, head_job;
  fifo_status_t fifo_status;

  // Input is taken while the queue has room and no sweep is running.
  assign in_ready_o = !fifo_status.full && !sweeping;
  assign accept     = in_valid_i && in_ready_o;

  bsng_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .func_i         (func_i),
    .data_byte_i    (data_byte_i),
    .region_start_i (region_start_i),
    .read_index_i   (read_index_i),
    .push_o         (push),
    .job_o          (push_job)
  );

  bsng_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (fifo_status)
  );

  bsng_back #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_i             (head_job),
    .fifo_i            (fifo_status),
    .pop_o             (pop),
    .sweeping_o        (sweeping),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .token_value_o     (token_value_o),
    .frequency_o       (frequency_o),
    .distinct_tokens_o (distinct_tokens_o)
  );

`ifndef SYNTHESIS
  // The queue is never pushed while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !fifo_status.full)
    else $error("job queue overflow");

  // The queue is never popped while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !fifo_status.empty)
    else $error("job queue underflow");

  // The distinct count cannot exceed the number of bins.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (32'(distinct_tokens_o) <= 32'(BIN_COUNT)))
    else $error("distinct count above bin count");

  // A bin outside the store always reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (32'(token_value_o) >= 32'(BIN_COUNT))) |-> (frequency_o == '0))
    else $error("nonzero count for a bin outside the store");
`endif

endmodule

@@ src/bsng_front.sv @@
module bsng_front #(
  parameter int unsigned MAX_DIM = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bsng_pkg::DIM_W-1:0]          cfg_wdata_i,
  input  logic                                accept_i,
  input  logic [1:0]                          func_i,
  input  logic [7:0]                          data_byte_i,
  input  logic                                region_start_i,
  input  logic [bsng_pkg::IDX_IN_W-1:0]       read_index_i,
  output logic                                push_o,
  output bsng_pkg::job_t                      job_o
);
  import bsng_pkg::*;

  localparam int unsigned HIST_W = 8 * MAX_DIM;

  logic [DIM_W-1:0]  dim_q;
  logic [DIM_W-1:0]  dim_eff;
  logic [HIST_W-1:0] hist_q, hist_d, hist_base;
  logic [DIM_W-1:0]  bir_q, bir_d, prev;
  logic [DIM_W:0]    bir_inc;
  logic [DIM_W-1:0]  bir_new;
  logic [HIST_W+7:0] wide;
  logic              has_token;

  // Window bookkeeping for the incoming byte.
  always_comb begin
    dim_eff   = (dim_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_q;
    prev      = region_start_i ? '0 : bir_q;
    hist_base = region_start_i ? '0 : hist_q;
    wide      = {hist_base, data_byte_i};
    bir_inc   = {1'b0, prev} + (DIM_W + 1)'(1);
    bir_new   = (bir_inc > {1'b0, dim_eff}) ? dim_eff : bir_inc[DIM_W-1:0];
    has_token = (dim_eff != '0) && ((prev >= dim_eff) || (bir_new == dim_eff));
  end

  // The window state advances on every accepted data byte.
  always_comb begin
    hist_d = hist_q;
    bir_d  = bir_q;
    if (accept_i && (func_i == FN_DATA)) begin
      hist_d = wide[HIST_W-1:0];
      bir_d  = bir_new;
    end
  end

  // Classify the transaction into a back end job.
  always_comb begin
    job_o.kind     = JOB_TOKENS;
    job_o.win      = WIN_W'(wide);
    job_o.dim      = dim_eff;
    job_o.multi    = prev >= dim_eff;
    job_o.read_idx = read_index_i;
    push_o         = 1'b0;
    case (func_i)
      FN_DATA: begin
        push_o = accept_i && has_token;
      end
      FN_READ: begin
        job_o.kind = JOB_READ;
        push_o     = accept_i;
      end
      FN_CLEAR: begin
        job_o.kind = JOB_CLEAR;
        push_o     = accept_i;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= DIM_W'(1);
      hist_q <= '0;
      bir_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        dim_q <= cfg_wdata_i;
      end
      hist_q <= hist_d;
      bir_q  <= bir_d;
    end
  end

endmodule

@@ src/bsng_fifo.sv @@
module bsng_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  bsng_pkg::job_t         job_i,
  input  logic                   pop_i,
  output bsng_pkg::job_t         job_o,
  output bsng_pkg::fifo_status_t status_o
);
  import bsng_pkg::*;

  job_t                  slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   count_q, count_d;

  assign job_o           = slot_q[rd_ptr_q];
  assign status_o.full   = count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
  assign status_o.empty  = count_q == '0;

  // Occupancy follows the push and pop strobes.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (FIFO_PTR_W + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (FIFO_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  // Job storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ src/bsng_back.sv @@
module bsng_back #(
  parameter int unsigned BIN_COUNT  = 65536,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bsng_pkg::job_t                      job_i,
  input  bsng_pkg::fifo_status_t              fifo_i,
  output logic                                pop_o,
  output logic                                sweeping_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bsng_pkg::IDX_IN_W-1:0]       token_value_o,
  output logic [bsng_pkg::FREQ_W-1:0]         frequency_o,
  output logic [bsng_pkg::DISTINCT_W-1:0]     distinct_tokens_o
);
  import bsng_pkg::*;

  localparam int unsigned IDX_W  = $clog2(BIN_COUNT);
  localparam int unsigned SEEN_W = $clog2(BIN_COUNT + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  back_state_e state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;

  // Token job in progress.
  job_t        job_q, job_d;
  logic        busy_q, busy_d;
  logic [2:0]  step_q, step_d;

  // Memory read stage and update stage.
  logic                  s1_valid, s1_read, s1_oob;
  logic [IDX_W-1:0]      s1_addr;
  logic                  s2_valid_q, s2_read_q, s2_oob_q;
  logic [IDX_W-1:0]      s2_addr_q;
  logic [IDX_IN_W-1:0]   s2_ridx_q;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  fwd_valid_q, fwd_valid_d;
  logic [IDX_W-1:0]      fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic [COUNT_BITS-1:0] cur, inc;
  logic [63:0]           cur_ext;
  logic [31:0]           seen_ext;
  logic [SEEN_W-1:0]     seen_q, seen_d;

  logic [COUNT_BITS-1:0] count_mem [BIN_COUNT];
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  logic                  out_valid_q, out_valid_d;
  logic [IDX_IN_W-1:0]   out_token_q;
  logic [FREQ_W-1:0]     out_freq_q;
  logic [DISTINCT_W-1:0] out_dist_q;

  logic                  head_valid, load_tok, issue_read, clear_pop, tok_wr, sweep;
  logic [WIN_W-1:0]      shifted, tok_mask, tok32;
  logic [31:0]           ridx32;
  logic                  tok_ok;

  // Head-of-queue decisions.
  always_comb begin
    head_valid = !fifo_i.empty && (state_q == BK_RUN);
    load_tok   = head_valid && (job_i.kind == JOB_TOKENS) && (!busy_q || (step_q == 3'd0));
    issue_read = head_valid && (job_i.kind == JOB_READ) && !busy_q && !out_valid_q &&
                 !(s2_valid_q && s2_read_q);
    clear_pop  = head_valid && (job_i.kind == JOB_CLEAR) && !busy_q;
    pop_o      = load_tok || issue_read || clear_pop;
    sweep      = state_q == BK_SWEEP;
    sweeping_o = sweep;
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_SWEEP: begin
        if (ptr_q == IDX_W'(BIN_COUNT - 1)) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (clear_pop) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!s2_valid_q) begin
          state_d = BK_SWEEP;
        end
      end
      default: begin
        state_d = BK_RUN;
      end
    endcase
  end

  // Sweep pointer, advanced only while clearing.
  always_comb begin
    ptr_d = '0;
    case (state_q)
      BK_SWEEP: ptr_d = ptr_q + IDX_W'(1);
      default:  ptr_d = '0;
    endcase
  end

  // Token selection: one window position per cycle, highest shift first.
  always_comb begin
    shifted = job_q.win >> step_q;
    case (job_q.dim)
      2'd1:    tok_mask = WIN_W'(32'h0000_00FF);
      2'd2:    tok_mask = WIN_W'(32'h0000_FFFF);
      default: tok_mask = WIN_W'(32'h00FF_FFFF);
    endcase
    tok32  = shifted & tok_mask;
    tok_ok = tok32 < 32'(BIN_COUNT);
    ridx32 = 32'(job_i.read_idx);
  end

  // Job register and step counter.
  always_comb begin
    job_d  = job_q;
    busy_d = busy_q;
    step_d = step_q;
    if (load_tok) begin
      job_d  = job_i;
      busy_d = 1'b1;
      step_d = job_i.multi ? 3'd7 : 3'd0;
    end else if (busy_q) begin
      if (step_q == 3'd0) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q - 3'd1;
      end
    end
  end

  // Read stage request.
  always_comb begin
    s1_valid = (busy_q && tok_ok) || issue_read;
    s1_read  = issue_read;
    s1_oob   = ridx32 >= 32'(BIN_COUNT);
    s1_addr  = busy_q ? tok32[IDX_W-1:0] : ridx32[IDX_W-1:0];
  end

  // Update stage: forward the previous write, then increment with saturation.
  always_comb begin
    cur      = (fwd_valid_q && (fwd_addr_q == s2_addr_q)) ? fwd_data_q : rdata_q;
    inc      = (cur == CNT_MAX) ? cur : cur + COUNT_BITS'(1);
    cur_ext  = 64'(cur);
    seen_ext = 32'(seen_q);
    tok_wr   = s2_valid_q && !s2_read_q;

    mem_we    = tok_wr || sweep;
    mem_waddr = sweep ? ptr_q : s2_addr_q;
    mem_wdata = sweep ? '0 : inc;

    fwd_valid_d = tok_wr && !sweep;

    seen_d = seen_q;
    if (sweep) begin
      seen_d = '0;
    end else if (tok_wr && (cur == '0)) begin
      seen_d = seen_q + SEEN_W'(1);
    end

    out_valid_d = out_valid_q;
    if (s2_valid_q && s2_read_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_SWEEP;
      ptr_q       <= '0;
      busy_q      <= 1'b0;
      step_q      <= '0;
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      busy_q      <= busy_d;
      step_q      <= step_d;
      s2_valid_q  <= s1_valid;
      fwd_valid_q <= fwd_valid_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pipeline payload and the result register.
  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    s2_read_q  <= s1_read;
    s2_oob_q   <= s1_oob;
    s2_addr_q  <= s1_addr;
    s2_ridx_q  <= job_i.read_idx;
    fwd_addr_q <= s2_addr_q;
    fwd_data_q <= inc;
    if (s2_valid_q && s2_read_q) begin
      out_token_q <= s2_ridx_q;
      out_freq_q  <= s2_oob_q ? '0 : cur_ext[FREQ_W-1:0];
      out_dist_q  <= seen_ext[DISTINCT_W-1:0];
    end
  end

  // Counter memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      count_mem[mem_waddr] <= mem_wdata;
    end
    if (s1_valid) begin
      rdata_q <= count_mem[s1_addr];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign token_value_o     = out_token_q;
  assign frequency_o       = out_freq_q;
  assign distinct_tokens_o = out_dist_q;

endmodule
